// ----- rtl/core/sitda_pkg.sv -----
// ----------------------------------------------------------------------------
// sitda_pkg
// shared types, character codes and sizing helpers for the decimal converter
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int CHAR_W      = 8;
  localparam int LEN_W       = 4;
  localparam int OUT_TDATA_W = 16;

  typedef logic [CHAR_W-1:0] char_t;
  typedef logic [LEN_W-1:0]  len_t;

  localparam char_t ASCII_ZERO  = 8'd48;
  localparam char_t ASCII_MINUS = 8'd45;

  // decimal digits that hold any value below 2**width (slight overestimate)
  function automatic int digit_count(input int width);
    digit_count = (width * 30103) / 100000 + 1;
  endfunction

endpackage

// ----- rtl/core/sitda_dabble.sv -----
// ----------------------------------------------------------------------------
// sitda_dabble
// one registered shift-and-add-3 step of the binary to bcd pipeline
// ----------------------------------------------------------------------------
module sitda_dabble #(
  parameter int VALUE_WIDTH = 32,
  parameter int NDIG        = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [NDIG*4-1:0]      in_bcd,
  input  logic [VALUE_WIDTH-1:0] in_rem,
  input  logic                   in_neg,
  output logic                   out_valid,
  output logic [NDIG*4-1:0]      out_bcd,
  output logic [VALUE_WIDTH-1:0] out_rem,
  output logic                   out_neg
);

  logic [NDIG*4-1:0] adj;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (in_bcd[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = in_bcd[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = in_bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_bcd <= {adj[NDIG*4-2:0], in_rem[VALUE_WIDTH-1]};
      out_rem <= {in_rem[VALUE_WIDTH-2:0], 1'b0};
      out_neg <= in_neg;
    end
  end

endmodule

// ----- rtl/core/sitda_ser.sv -----
// ----------------------------------------------------------------------------
// sitda_ser
// character serialiser: sign, then significant digits, into an output register
// ----------------------------------------------------------------------------
module sitda_ser #(
  parameter int NDIG = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [NDIG*4-1:0]     in_bcd,
  input  logic                  in_neg,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sitda_pkg::char_t      out_char,
  output logic                  out_last,
  output sitda_pkg::len_t       out_len
);
  import sitda_pkg::*;

  localparam int IDX_W = $clog2(NDIG);
  localparam int CNT_W = $clog2(NDIG + 1);
  localparam int SUM_W = CNT_W + LEN_W;

  logic              busy;
  logic              neg_pend;
  logic [IDX_W-1:0]  idx;
  len_t              len;
  logic [NDIG*4-1:0] bcd;

  logic              emit;
  logic              finish;
  logic              load;
  logic [CNT_W-1:0]  nsig;
  logic [SUM_W-1:0]  len_sum;
  logic [3:0]        digit;

  always_comb begin
    nsig = CNT_W'(1);
    for (int i = 0; i < NDIG; i++) begin
      if (in_bcd[i*4 +: 4] != 4'd0) begin
        nsig = CNT_W'(i + 1);
      end
    end
  end

  assign len_sum  = SUM_W'(nsig) + SUM_W'(in_neg);
  assign digit    = bcd[idx*4 +: 4];
  assign emit     = busy && (!out_valid || out_ready);
  assign finish   = emit && !neg_pend && (idx == '0);
  assign in_ready = !busy || finish;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
    end else if (finish) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bcd      <= in_bcd;
      neg_pend <= in_neg;
      idx      <= IDX_W'(nsig - CNT_W'(1));
      len      <= len_sum[LEN_W-1:0];
    end else if (emit) begin
      if (neg_pend) begin
        neg_pend <= 1'b0;
      end else if (idx != '0) begin
        idx <= idx - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (neg_pend) begin
        out_char <= ASCII_MINUS;
        out_last <= 1'b0;
        out_len  <= '0;
      end else begin
        out_char <= ASCII_ZERO + char_t'(digit);
        out_last <= (idx == '0);
        out_len  <= (idx == '0) ? len : '0;
      end
    end
  end

endmodule

// ----- rtl/core/signed_int_to_decimal_ascii_core.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// signed integer to decimal ascii text, one character per output transaction
// ----------------------------------------------------------------------------
// Each input transaction carries one two's complement integer of VALUE_WIDTH
// bits. The block sends its decimal text most significant digit first, with a
// leading '-' for negative values; zero gives a single '0' and the most
// negative value converts correctly. The last character of a number has tlast
// set and carries the character count (modulo 16) in tdata[11:8]. A sign stage
// and VALUE_WIDTH shift-and-add-3 stages form the pipeline, which feeds the
// serialiser. The output side takes one character per cycle while m_tready
// is high, and a number has 1 to 11 characters at 32 bits; the serialiser,
// which holds one number at a time, sets that rate and stalls the pipeline.
module signed_int_to_decimal_ascii_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // value
  input  logic [((VALUE_WIDTH+7)/8)*8-1:0]       s_tdata,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // character [7:0], total_length [11:8]
  output logic [sitda_pkg::OUT_TDATA_W-1:0]      m_tdata,
  output logic                                   m_tlast
);
  import sitda_pkg::*;

  localparam int NDIG = digit_count(VALUE_WIDTH);

  logic                   valid_s [0:VALUE_WIDTH];
  logic [NDIG*4-1:0]      bcd_s   [0:VALUE_WIDTH];
  logic [VALUE_WIDTH-1:0] rem_s   [0:VALUE_WIDTH];
  logic                   neg_s   [0:VALUE_WIDTH];

  logic                   advance;
  logic                   ser_ready;
  logic [VALUE_WIDTH-1:0] value;
  char_t                  out_char;
  len_t                   out_len;

  assign value    = s_tdata[VALUE_WIDTH-1:0];
  assign advance  = !valid_s[VALUE_WIDTH] || ser_ready;
  assign s_tready = advance;

  // sign stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_s[0] <= 1'b0;
    end else if (advance) begin
      valid_s[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      neg_s[0] <= value[VALUE_WIDTH-1];
      rem_s[0] <= value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
      bcd_s[0] <= '0;
    end
  end

  for (genvar g = 0; g < VALUE_WIDTH; g++) begin : g_dabble
    sitda_dabble #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .NDIG        (NDIG)
    ) u_dabble (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .in_valid  (valid_s[g]),
      .in_bcd    (bcd_s[g]),
      .in_rem    (rem_s[g]),
      .in_neg    (neg_s[g]),
      .out_valid (valid_s[g+1]),
      .out_bcd   (bcd_s[g+1]),
      .out_rem   (rem_s[g+1]),
      .out_neg   (neg_s[g+1])
    );
  end

  sitda_ser #(
    .NDIG (NDIG)
  ) u_ser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (valid_s[VALUE_WIDTH]),
    .in_ready  (ser_ready),
    .in_bcd    (bcd_s[VALUE_WIDTH]),
    .in_neg    (neg_s[VALUE_WIDTH]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_char  (out_char),
    .out_last  (m_tlast),
    .out_len   (out_len)
  );

  assign m_tdata = {{(OUT_TDATA_W-CHAR_W-LEN_W){1'b0}}, out_len, out_char};

endmodule
